// ===== rtl/marker_length_xor_frame_receiver_unit_defines.svh =====
// ------------------------------------------------------------------------
// marker length xor frame receiver assertion macros
// shared concurrent assertion forms, clocked on clk, off during reset
// ------------------------------------------------------------------------
`ifndef MARKER_LENGTH_XOR_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define MARKER_LENGTH_XOR_FRAME_RECEIVER_UNIT_DEFINES_SVH

// same-cycle implication
`define MLXFR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MLXFR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/mlxfr_pkg.sv =====
// ------------------------------------------------------------------------
// mlxfr_pkg
// types and constants shared by the frame receiver modules
// ------------------------------------------------------------------------
`default_nettype none

package mlxfr_pkg;

	localparam logic [7:0] START_MARKER_RST = 8'hF5;
	localparam logic [7:0] END_MARKER_RST   = 8'hF6;
	localparam logic [8:0] MIN_COUNT        = 9'd2;
	localparam logic [8:0] FULL_COUNT       = 9'd256;

	// register indexes
	localparam logic REG_START_MARKER = 1'b0;
	localparam logic REG_END_MARKER   = 1'b1;

	// result kinds
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_CSUM_BAD  = 2'd1,
		STAT_TOO_SHORT = 2'd2,
		STAT_END_BAD   = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		PH_HUNT  = 4'b0001,
		PH_COUNT = 4'b0010,
		PH_BODY  = 4'b0100,
		PH_END   = 4'b1000
	} phase_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] payload;
		logic       is_code;
		status_t    status;
	} res_t;

endpackage

`default_nettype wire

// ===== rtl/mlxfr_parser.sv =====
// ------------------------------------------------------------------------
// mlxfr_parser
// frame state machine: hunts for the start marker, tracks the count,
// passes out payload bytes, checks the xor, the minimum count and the end marker
// ------------------------------------------------------------------------
`default_nettype none
`include "marker_length_xor_frame_receiver_unit_defines.svh"

module mlxfr_parser (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              beat,
	input  wire  [7:0]       rx_byte,
	input  wire  [7:0]       start_marker,
	input  wire  [7:0]       end_marker,
	output logic             res_push,
	output mlxfr_pkg::res_t  res_data
);
	import mlxfr_pkg::*;

	phase_t     phase_q, phase_d;
	logic [8:0] bytes_left_q, bytes_left_d;
	logic [7:0] running_xor_q, running_xor_d;
	logic       csum_ok_q, csum_ok_d;
	logic       too_short_q, too_short_d;
	logic       first_q, first_d;
	logic [8:0] count;

	assign count = (rx_byte == 8'h00) ? FULL_COUNT : {1'b0, rx_byte};

	always_comb begin
		phase_d       = phase_q;
		bytes_left_d  = bytes_left_q;
		running_xor_d = running_xor_q;
		csum_ok_d     = csum_ok_q;
		too_short_d   = too_short_q;
		first_d       = first_q;
		res_push      = 1'b0;
		res_data      = '{kind: KIND_PAYLOAD, payload: 8'h00, is_code: 1'b0,
			status: STAT_OK};
		case (phase_q)
			PH_HUNT: begin
				if (rx_byte == start_marker) begin
					phase_d = PH_COUNT;
				end
			end
			PH_COUNT: begin
				bytes_left_d  = count;
				too_short_d   = (count < MIN_COUNT);
				running_xor_d = 8'h00;
				csum_ok_d     = 1'b0;
				first_d       = 1'b1;
				phase_d       = PH_BODY;
			end
			PH_BODY: begin
				first_d = 1'b0;
				if (bytes_left_q <= 9'd1) begin
					// checksum byte
					csum_ok_d    = (rx_byte == running_xor_q);
					bytes_left_d = 9'd0;
					phase_d      = PH_END;
				end else begin
					res_push         = 1'b1;
					res_data.payload = rx_byte;
					res_data.is_code = first_q;
					running_xor_d    = running_xor_q ^ rx_byte;
					bytes_left_d     = bytes_left_q - 9'd1;
				end
			end
			PH_END: begin
				res_push      = 1'b1;
				res_data.kind = KIND_STATUS;
				if (rx_byte != end_marker) begin
					res_data.status = STAT_END_BAD;
				end else if (too_short_q) begin
					res_data.status = STAT_TOO_SHORT;
				end else if (!csum_ok_q) begin
					res_data.status = STAT_CSUM_BAD;
				end else begin
					res_data.status = STAT_OK;
				end
				phase_d = PH_HUNT;
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HUNT;
			bytes_left_q  <= 9'd0;
			running_xor_q <= 8'h00;
			csum_ok_q     <= 1'b0;
			too_short_q   <= 1'b0;
			first_q       <= 1'b0;
		end else if (beat) begin
			phase_q       <= phase_d;
			bytes_left_q  <= bytes_left_d;
			running_xor_q <= running_xor_d;
			csum_ok_q     <= csum_ok_d;
			too_short_q   <= too_short_d;
			first_q       <= first_d;
		end
	end

	`MLXFR_ASSERT_NEXT(a_count_opens_body, beat && phase_q == PH_COUNT, phase_q == PH_BODY && running_xor_q == 8'h00 && first_q, "count beat did not open body")
	`MLXFR_ASSERT_NEXT(a_status_ends_frame, beat && res_push && res_data.kind == KIND_STATUS, phase_q == PH_HUNT, "status beat did not return to hunt")
	`MLXFR_ASSERT_NOW(a_end_count_zero, phase_q == PH_END, bytes_left_q == 9'd0, "byte count not zero at frame end")

endmodule

`default_nettype wire

// ===== rtl/mlxfr_outbuf.sv =====
// ------------------------------------------------------------------------
// mlxfr_outbuf
// result register with one skid entry, so a new beat can enter while
// the previous result still waits on a stalled receiver
// ------------------------------------------------------------------------
`default_nettype none
`include "marker_length_xor_frame_receiver_unit_defines.svh"

module mlxfr_outbuf (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push,
	input  wire mlxfr_pkg::res_t  push_data,
	output logic                  full,
	output logic                  res_valid,
	input  wire                   res_stall,
	output mlxfr_pkg::res_t       res_data
);
	import mlxfr_pkg::*;

	logic head_v_q;
	logic skid_v_q;
	res_t head_q;
	res_t skid_q;
	logic pop;

	assign pop       = head_v_q && !res_stall;
	assign full      = skid_v_q;
	assign res_valid = head_v_q;
	assign res_data  = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop) begin
			if (skid_v_q) begin
				skid_v_q <= push;
			end else begin
				head_v_q <= push;
			end
		end else if (!head_v_q) begin
			head_v_q <= push;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_v_q) begin
				head_q <= skid_q;
				skid_q <= push_data;
			end else begin
				head_q <= push_data;
			end
		end else if (!head_v_q) begin
			head_q <= push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	`MLXFR_ASSERT_NOW(a_skid_needs_head, skid_v_q, head_v_q, "skid entry held without head entry")
	`MLXFR_ASSERT_NEXT(a_stall_fills_skid, head_v_q && res_stall && !skid_v_q && push, skid_v_q && head_v_q, "stalled push did not land in skid entry")
	`MLXFR_ASSERT_NEXT(a_pop_keeps_order, pop && skid_v_q, head_v_q && head_q == $past(skid_q), "skid entry not moved to head")

endmodule

`default_nettype wire

// ===== rtl/marker_length_xor_frame_receiver_unit.sv =====
// Length-prefixed frame receiver with xor checksum.
// Input channel: rx_byte with rx_valid / rx_stall, one received serial byte
// per beat. Output channel: result_kind, payload_byte, is_code_byte and
// frame_status with res_valid / res_stall. A beat moves at a rising edge
// with valid high and stall low.
// Each code and data byte of a frame gives one payload result; the byte
// after the checksum gives one status result; marker, count and checksum
// bytes give none.
// A result is registered in the result buffer before it shows on res_valid;
// one byte is taken every cycle while rx_stall is low.
// The result register has one skid entry behind it, so rx_stall rises only
// when both entries hold results that the receiver has not taken.
// Configuration: cfg_we, cfg_index and cfg_data write start_marker (index 0)
// or end_marker (index 1); write only while no frame is in flight.
// Reset (arst_n low) returns to hunting for the start marker, empties the
// result entries and loads the markers with 0xF5 and 0xF6.
// ------------------------------------------------------------------------
// marker_length_xor_frame_receiver_unit
// top level: configuration registers, frame parser and result buffer
// ------------------------------------------------------------------------
`default_nettype none

module marker_length_xor_frame_receiver_unit (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        cfg_we,
	input  wire        cfg_index,
	input  wire  [7:0] cfg_data,
	input  wire        rx_valid,
	output logic       rx_stall,
	input  wire  [7:0] rx_byte,
	output logic       res_valid,
	input  wire        res_stall,
	output logic       result_kind,
	output logic [7:0] payload_byte,
	output logic       is_code_byte,
	output logic [1:0] frame_status
);
	import mlxfr_pkg::*;

	logic [7:0] start_marker_q;
	logic [7:0] end_marker_q;
	logic       beat;
	logic       push;
	logic       full;
	res_t       push_data;
	res_t       out_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= START_MARKER_RST;
			end_marker_q   <= END_MARKER_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START_MARKER: start_marker_q <= cfg_data;
				REG_END_MARKER:   end_marker_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign rx_stall = full;
	assign beat     = rx_valid && !full;

	mlxfr_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.beat         (beat),
		.rx_byte      (rx_byte),
		.start_marker (start_marker_q),
		.end_marker   (end_marker_q),
		.res_push     (push),
		.res_data     (push_data)
	);

	mlxfr_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (beat && push),
		.push_data (push_data),
		.full      (full),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (out_data)
	);

	assign result_kind  = out_data.kind;
	assign payload_byte = out_data.payload;
	assign is_code_byte = out_data.is_code;
	assign frame_status = out_data.status;

endmodule

`default_nettype wire
